[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file of the range filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define URF_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Clocked assertion that also holds during reset.
`define URF_ASSERT(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

[rtl/core/urf_pkg.sv]
// Package of the ultrasonic range filter: widths, reset values, register codes, types.
`timescale 1ns / 1ps
`default_nettype none
package urf_pkg;

    // field widths
    localparam int DIST_W      = 10;
    localparam int TICK_MS_W   = 8;
    localparam int PERIOD_W    = 10;
    localparam int ELAPSED_W   = 11;

    // configuration port
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 10;

    localparam logic [CFG_IDX_W-1:0] REG_TICK_MS   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_MS = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_CM    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CM    = 4'd3;

    localparam logic [TICK_MS_W-1:0] TICK_MS_RST = 8'd10;
    localparam logic [PERIOD_W-1:0]  PERIOD_RST  = 10'd50;
    localparam logic [DIST_W-1:0]    MIN_CM_RST  = 10'd2;
    localparam logic [DIST_W-1:0]    MAX_CM_RST  = 10'd400;

    // parameter defaults
    localparam int WINDOW_LEN_DEF  = 5;
    localparam int TICKS_WIDTH_DEF = 24;

    // cm = floor(ticks * 2941 / 1e6), the halving folded into the factor.
    // 1e6 = 64 * 15625: drop six bits, then multiply by ceil(2^39 / 15625),
    // exact for a dividend below 2^25.
    localparam int SOUND_HALF_W = 12;
    localparam logic [SOUND_HALF_W-1:0] SOUND_HALF = 12'd2941;
    // ticks at or above 2^LOW_W always give more than 1023 cm
    localparam int LOW_W     = 19;
    localparam int PROD_W    = 31;
    localparam int PRE_SHIFT = 6;
    localparam int X_W       = PROD_W - PRE_SHIFT;
    localparam int RECIP_W   = 26;
    localparam logic [RECIP_W-1:0] RECIP_15625 = 26'd35184373;
    localparam int MUL_W     = X_W + RECIP_W;
    localparam int SCALE_K   = 39;
    localparam int CM_W      = MUL_W - SCALE_K;

    // output queue
    localparam int OUT_Q_DEPTH = 8;
    localparam int OUT_Q_AW    = 3;
    localparam int OUT_Q_CW    = 4;

    typedef struct packed {
        logic              trigger_start;
        logic              reading_accepted;
        logic [DIST_W-1:0] filtered_distance_cm;
        logic              has_reading;
    } t_result;

endpackage
`default_nettype wire

[rtl/core/urf_in_if.sv]
// Input channel of the range filter: one scheduler tick with its echo.
`timescale 1ns / 1ps
`default_nettype none
interface urf_in_if #(
    parameter int TICKS_W = urf_pkg::TICKS_WIDTH_DEF
) ();
    logic               valid;
    logic               ready;
    logic               echo_ready;
    logic [TICKS_W-1:0] echo_ticks;

    modport source (output valid, output echo_ready, output echo_ticks, input ready);
    modport sink   (input valid, input echo_ready, input echo_ticks, output ready);
endinterface
`default_nettype wire

[rtl/core/urf_out_if.sv]
// Output channel of the range filter: one result per tick.
`timescale 1ns / 1ps
`default_nettype none
interface urf_out_if ();
    import urf_pkg::*;

    logic              valid;
    logic              ready;
    logic              trigger_start;
    logic              reading_accepted;
    logic [DIST_W-1:0] filtered_distance_cm;
    logic              has_reading;

    modport source (output valid, output trigger_start, output reading_accepted,
                    output filtered_distance_cm, output has_reading, input ready);
    modport sink   (input valid, input trigger_start, input reading_accepted,
                    input filtered_distance_cm, input has_reading, output ready);
endinterface
`default_nettype wire

[rtl/core/urf_cfg_if.sv]
// Configuration write channel of the range filter.
`timescale 1ns / 1ps
`default_nettype none
interface urf_cfg_if ();
    import urf_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/urf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module urf_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 5,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // a read of the address written in the same cycle returns the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

[rtl/core/ultrasonic_range_filter_core.sv]
// Top level of the ultrasonic range filter: trigger timer, echo conversion, moving average.
//
// Usage:
//   i_in carries one scheduler tick per transaction: echo_ready and echo_ticks.
//   o_out returns exactly one result per tick, in order: trigger_start,
//   reading_accepted, filtered_distance_cm and the sticky has_reading flag.
//   i_cfg writes registers 0..3 (tick_ms, sample_period_ms, min_distance_cm,
//   max_distance_cm); other indexes are ignored; i_cfg.ready is always high.
// Timing:
//   A result is valid on o_out once its tick has passed registers r1 to r4 and the queue.
//   One tick per cycle is sustained while i_in.ready is high: conversion runs
//   in two multiplier stages, the ring lives in a RAM read one cycle and written
//   back the next, and a running sum register feeds a reciprocal multiply for the mean.
//   Results wait in an 8-entry queue; i_in.ready drops while eight ticks are
//   outstanding, so a stalled receiver holds the input after that many.
// Reset:
//   Synchronous, active low. Registers take their reset values, the ring
//   reads as all zero at once through per-entry valid bits (no clearing
//   pass), and the pipeline and queue are emptied.
`timescale 1ns / 1ps
`default_nettype none
module ultrasonic_range_filter_core #(
    parameter int WINDOW_LEN  = urf_pkg::WINDOW_LEN_DEF,
    parameter int TICKS_WIDTH = urf_pkg::TICKS_WIDTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    urf_in_if.sink     i_in,
    urf_out_if.source  o_out,
    urf_cfg_if.sink    i_cfg
);
    import urf_pkg::*;

    localparam int SLOT_W   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int SUM_W    = DIST_W + $clog2(WINDOW_LEN);
    localparam int DIV_K    = SUM_W + $clog2(WINDOW_LEN);
    localparam int DIV_M_W  = SUM_W + 2;
    localparam int DIV_M_INT = ((1 << DIV_K) + WINDOW_LEN - 1) / WINDOW_LEN;
    localparam logic [DIV_M_W-1:0] DIV_M = DIV_M_W'(DIV_M_INT);
    localparam int MEAN_PW  = SUM_W + DIV_M_W;

    // configuration registers
    logic [TICK_MS_W-1:0] r_tick_ms;
    logic [PERIOD_W-1:0]  r_period_ms;
    logic [DIST_W-1:0]    r_min_cm;
    logic [DIST_W-1:0]    r_max_cm;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_ms   <= TICK_MS_RST;
            r_period_ms <= PERIOD_RST;
            r_min_cm    <= MIN_CM_RST;
            r_max_cm    <= MAX_CM_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_TICK_MS:   r_tick_ms   <= i_cfg.data[TICK_MS_W-1:0];
                REG_PERIOD_MS: r_period_ms <= i_cfg.data[PERIOD_W-1:0];
                REG_MIN_CM:    r_min_cm    <= i_cfg.data[DIST_W-1:0];
                REG_MAX_CM:    r_max_cm    <= i_cfg.data[DIST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // credit: ticks taken and not yet delivered, bounded by the queue depth
    logic [OUT_Q_CW-1:0] r_credit;
    logic                w_in_acc;
    logic                w_out_pop;

    assign i_in.ready = (r_credit < OUT_Q_CW'(OUT_Q_DEPTH));
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_pop  = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            r_credit <= r_credit + OUT_Q_CW'(w_in_acc) - OUT_Q_CW'(w_out_pop);
        end
    end

    // stage 0: sample timer and first conversion product
    logic [ELAPSED_W-1:0]   r_elapsed;
    logic [ELAPSED_W-1:0]   n_elapsed;
    logic                   w_trig;
    logic [TICKS_WIDTH-1:0] w_ticks;
    logic [LOW_W-1:0]       w_ticks_low;
    logic                   w_huge;

    assign n_elapsed   = r_elapsed + ELAPSED_W'(r_tick_ms);
    assign w_trig      = (n_elapsed >= ELAPSED_W'(r_period_ms));
    assign w_ticks     = i_in.echo_ticks;
    assign w_ticks_low = LOW_W'(w_ticks);
    assign w_huge      = ((w_ticks >> LOW_W) != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= '0;
        end else if (w_in_acc) begin
            r_elapsed <= w_trig ? '0 : n_elapsed;
        end
    end

    logic              r1_vld;
    logic              r1_trig;
    logic              r1_echo;
    logic              r1_huge;
    logic [PROD_W-1:0] r1_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= w_in_acc;
        end
        r1_trig <= w_trig;
        r1_echo <= i_in.echo_ready;
        r1_huge <= w_huge;
        r1_prod <= PROD_W'(w_ticks_low) * PROD_W'(SOUND_HALF);
    end

    // stage 1: divide by 1e6 through shift and reciprocal multiply
    logic [X_W-1:0]   w_x;
    logic [MUL_W-1:0] w_q_full;

    assign w_x      = r1_prod[PROD_W-1:PRE_SHIFT];
    assign w_q_full = MUL_W'(w_x) * MUL_W'(RECIP_15625);

    logic            r2_vld;
    logic            r2_trig;
    logic            r2_echo;
    logic            r2_huge;
    logic [CM_W-1:0] r2_cm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_trig <= r1_trig;
        r2_echo <= r1_echo;
        r2_huge <= r1_huge;
        r2_cm   <= w_q_full[SCALE_K +: CM_W];
    end

    // stage 2: window check, read the slot about to be overwritten
    logic [SLOT_W-1:0]     r_slot;
    logic [WINDOW_LEN-1:0] r_entry_vld;
    logic                  w_ok;
    logic                  w_fwd;

    logic              r3_vld;
    logic              r3_trig;
    logic              r3_ok;
    logic              r3_fwd;
    logic              r3_old_vld;
    logic [SLOT_W-1:0] r3_slot;
    logic [DIST_W-1:0] r3_cm;

    assign w_ok = r2_vld && r2_echo && !r2_huge
               && (r2_cm >= CM_W'(r_min_cm)) && (r2_cm <= CM_W'(r_max_cm));
    // the write-back in stage 3 targets the same slot: take its word instead
    assign w_fwd = r3_vld && r3_ok && (r3_slot == r_slot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else if (w_ok) begin
            r_slot <= (r_slot == SLOT_W'(WINDOW_LEN - 1)) ? '0 : r_slot + SLOT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
        r3_trig    <= r2_trig;
        r3_ok      <= w_ok;
        r3_fwd     <= w_fwd;
        r3_old_vld <= r_entry_vld[r_slot];
        r3_slot    <= r_slot;
        r3_cm      <= r2_cm[DIST_W-1:0];
    end

    // stage 3: write back the reading and update the running sum
    logic [DIST_W-1:0] w_ram_rdata;
    logic [DIST_W-1:0] w_old;
    logic [DIST_W-1:0] r_last_cm;
    logic [SUM_W-1:0]  r_sum;
    logic              w_wr;

    assign w_wr  = r3_vld && r3_ok;
    assign w_old = r3_fwd ? r_last_cm : (r3_old_vld ? w_ram_rdata : '0);

    urf_ram #(
        .WIDTH (DIST_W),
        .DEPTH (WINDOW_LEN),
        .AW    (SLOT_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_wr),
        .i_waddr (r3_slot),
        .i_wdata (r3_cm),
        .i_re    (w_ok),
        .i_raddr (r_slot),
        .o_rdata (w_ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_vld <= '0;
            r_sum       <= '0;
        end else if (w_wr) begin
            r_entry_vld[r3_slot] <= 1'b1;
            r_sum <= r_sum + SUM_W'(r3_cm) - SUM_W'(w_old);
        end
        if (w_wr) begin
            r_last_cm <= r3_cm;
        end
    end

    logic r4_vld;
    logic r4_trig;
    logic r4_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
        r4_trig <= r3_trig;
        r4_ok   <= w_wr;
    end

    // stage 4: mean by reciprocal multiply, hold the average, queue the result
    logic [MEAN_PW-1:0] w_mean_prod;
    logic [DIST_W-1:0]  w_mean;
    logic [DIST_W-1:0]  r_avg;
    logic               r_rdy;
    logic [DIST_W-1:0]  n_avg;
    logic               n_rdy;
    t_result            w_res;

    assign w_mean_prod = MEAN_PW'(r_sum) * MEAN_PW'(DIV_M);
    assign w_mean      = w_mean_prod[DIV_K +: DIST_W];
    assign n_avg       = r4_ok ? w_mean : r_avg;
    assign n_rdy       = r_rdy | r4_ok;

    always_comb begin
        w_res.trigger_start        = r4_trig;
        w_res.reading_accepted     = r4_ok;
        w_res.filtered_distance_cm = n_avg;
        w_res.has_reading          = n_rdy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg <= '0;
            r_rdy <= 1'b0;
        end else if (r4_vld) begin
            r_avg <= n_avg;
            r_rdy <= n_rdy;
        end
    end

    // output queue; the credit check keeps it from overflowing
    t_result             r_q [OUT_Q_DEPTH];
    logic [OUT_Q_AW-1:0] r_q_wr;
    logic [OUT_Q_AW-1:0] r_q_rd;
    logic [OUT_Q_CW-1:0] r_q_cnt;
    t_result             w_q_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wr  <= '0;
            r_q_rd  <= '0;
            r_q_cnt <= '0;
        end else begin
            if (r4_vld) begin
                r_q_wr <= r_q_wr + OUT_Q_AW'(1);
            end
            if (w_out_pop) begin
                r_q_rd <= r_q_rd + OUT_Q_AW'(1);
            end
            r_q_cnt <= r_q_cnt + OUT_Q_CW'(r4_vld) - OUT_Q_CW'(w_out_pop);
        end
        if (r4_vld) begin
            r_q[r_q_wr] <= w_res;
        end
    end

    assign w_q_head                   = r_q[r_q_rd];
    assign o_out.valid                = (r_q_cnt != '0);
    assign o_out.trigger_start        = w_q_head.trigger_start;
    assign o_out.reading_accepted     = w_q_head.reading_accepted;
    assign o_out.filtered_distance_cm = w_q_head.filtered_distance_cm;
    assign o_out.has_reading          = w_q_head.has_reading;

endmodule
`default_nettype wire

[rtl/core/urf_checker.sv]
// Port-level assertions of the range filter and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module urf_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic i_reading_accepted,
    input wire logic i_has_reading
);
    // a result with has_reading set has been delivered
    logic r_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (i_out_valid && i_out_ready && i_has_reading) begin
            r_seen <= 1'b1;
        end
    end

    `URF_ASSERT_RST(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)
    `URF_ASSERT(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid)
    `URF_ASSERT_RST(a_ready_sticky, i_clk, i_rst_n, i_out_valid && r_seen |-> i_has_reading)
    `URF_ASSERT_RST(a_accept_sets_ready, i_clk, i_rst_n,
                    i_out_valid && i_reading_accepted |-> i_has_reading)

endmodule

bind ultrasonic_range_filter_core urf_checker u_urf_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_reading_accepted (o_out.reading_accepted),
    .i_has_reading      (o_out.has_reading)
);
`default_nettype wire

[dv/tb_ultrasonic_range_filter_core.sv]
// Testbench of ultrasonic_range_filter_core: directed and random ticks under several register settings.
`timescale 1ns / 1ps
module tb_ultrasonic_range_filter_core;
    import urf_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int RST_CYCLES      = 4;
    localparam int MAX_WAIT        = 18;
    localparam int SETTLE_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RING_LEN        = 5;
    localparam int TICKS_W         = 24;
    localparam int RANDOM_PHASES   = 4;
    localparam int TICKS_PER_PHASE = 155;

    localparam longint unsigned SOUND_FACTOR  = 5882;
    localparam longint unsigned SOUND_DIVISOR = 1000000;
    localparam longint unsigned ROUND_TRIP    = 2;

    // index that maps to no register
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 4'd14;

    class range_filter_scoreboard;
        logic [TICK_MS_W-1:0] tick_ms;
        logic [PERIOD_W-1:0]  period_ms;
        logic [DIST_W-1:0]    min_cm;
        logic [DIST_W-1:0]    max_cm;
        logic [ELAPSED_W-1:0] elapsed_ms;
        logic [DIST_W-1:0]    ring [RING_LEN];
        int                   slot;
        logic [DIST_W-1:0]    mean_cm;
        logic                 ready_seen;
        t_result              due_results [$];
        int                   errors;

        function new();
            tick_ms    = TICK_MS_RST;
            period_ms  = PERIOD_RST;
            min_cm     = MIN_CM_RST;
            max_cm     = MAX_CM_RST;
            elapsed_ms = '0;
            foreach (ring[i]) ring[i] = '0;
            slot       = 0;
            mean_cm    = '0;
            ready_seen = 1'b0;
            errors     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_TICK_MS:   tick_ms   = data[TICK_MS_W-1:0];
                REG_PERIOD_MS: period_ms = data;
                REG_MIN_CM:    min_cm    = data;
                REG_MAX_CM:    max_cm    = data;
                default: ;
            endcase
        endfunction

        function void note_tick(logic echo, logic [TICKS_W-1:0] ticks);
            t_result          r;
            longint unsigned  cm;
            int unsigned      sum;
            r = '0;
            elapsed_ms = elapsed_ms + tick_ms;
            if (elapsed_ms >= period_ms) begin
                elapsed_ms      = '0;
                r.trigger_start = 1'b1;
            end
            if (echo) begin
                // keep the product at full width, then halve for the round trip
                cm = 64'(ticks);
                cm = cm * SOUND_FACTOR / SOUND_DIVISOR / ROUND_TRIP;
                if (cm >= min_cm && cm <= max_cm) begin
                    ring[slot] = cm[DIST_W-1:0];
                    slot       = (slot + 1) % RING_LEN;
                    sum        = 0;
                    foreach (ring[i]) sum += ring[i];
                    mean_cm            = DIST_W'(sum / RING_LEN);
                    ready_seen         = 1'b1;
                    r.reading_accepted = 1'b1;
                end
            end
            r.filtered_distance_cm = mean_cm;
            r.has_reading          = ready_seen;
            due_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [DIST_W-1:0] want, logic [DIST_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (due_results.size() == 0) begin
                $error("result with no tick outstanding: %p", got);
                errors++;
                return;
            end
            want = due_results.pop_front();
            compare_field("trigger_start", want.trigger_start, got.trigger_start);
            compare_field("reading_accepted", want.reading_accepted, got.reading_accepted);
            compare_field("filtered_distance_cm", want.filtered_distance_cm,
                          got.filtered_distance_cm);
            compare_field("has_reading", want.has_reading, got.has_reading);
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   send_burst = 1'b0;

    urf_in_if #(.TICKS_W(TICKS_W)) in_ch ();
    urf_out_if                     out_ch ();
    urf_cfg_if                     cfg_ch ();

    range_filter_scoreboard scoreboard = new();

    ultrasonic_range_filter_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    function automatic int draw_wait(bit burst);
        return burst ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // smallest echo width that converts to at least cm
    function automatic logic [TICKS_W-1:0] ticks_for_cm(int unsigned cm);
        longint unsigned t;
        t = (longint'(cm) * ROUND_TRIP * SOUND_DIVISOR + SOUND_FACTOR - 1) / SOUND_FACTOR;
        return t[TICKS_W-1:0];
    endfunction

    task automatic send_tick(logic echo, logic [TICKS_W-1:0] ticks);
        int gap;
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        gap = draw_wait(send_burst);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.echo_ready <= echo;
        in_ch.echo_ticks <= ticks;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        scoreboard.note_tick(echo, ticks);
    endtask

    task automatic send_random_ticks(int count);
        logic                echo;
        logic [TICKS_W-1:0]  ticks;
        int unsigned         lo;
        int unsigned         hi;
        int unsigned         cm;
        int unsigned         pick;
        repeat (count) begin
            lo    = (scoreboard.min_cm < scoreboard.max_cm) ? scoreboard.min_cm : scoreboard.max_cm;
            hi    = (scoreboard.min_cm < scoreboard.max_cm) ? scoreboard.max_cm : scoreboard.min_cm;
            pick  = $urandom_range(0, 99);
            echo  = 1'b1;
            if (pick < 15) begin
                echo  = 1'b0;
                ticks = TICKS_W'($urandom);
            end else if (pick < 25) begin
                ticks = TICKS_W'($urandom);
            end else if (pick < 35) begin
                // land on either side of a window edge
                case ($urandom_range(0, 3))
                    0:       ticks = ticks_for_cm(lo);
                    1:       ticks = ticks_for_cm(lo) - TICKS_W'(1);
                    2:       ticks = ticks_for_cm(hi + 1) - TICKS_W'(1);
                    default: ticks = ticks_for_cm(hi + 1);
                endcase
            end else begin
                cm    = $urandom_range((lo > 20) ? lo - 20 : 0, (hi + 20 > 1023) ? 1023 : hi + 20);
                ticks = TICKS_W'(ticks_for_cm(cm)
                      + $urandom_range(0, ticks_for_cm(cm + 1) - ticks_for_cm(cm) - 1));
            end
            send_tick(echo, ticks);
        end
    endtask

    task automatic write_settings(logic [CFG_DATA_W-1:0] tick, logic [CFG_DATA_W-1:0] period,
                                  logic [CFG_DATA_W-1:0] lo_cm, logic [CFG_DATA_W-1:0] hi_cm);
        logic [CFG_IDX_W-1:0]  idx [5];
        logic [CFG_DATA_W-1:0] val [5];
        idx = '{REG_TICK_MS, REG_PERIOD_MS, REG_MIN_CM, REG_MAX_CM, REG_UNMAPPED};
        val = '{tick, period, lo_cm, hi_cm, CFG_DATA_W'($urandom)};
        // drain the block before touching registers
        in_ch.valid <= 1'b0;
        while (scoreboard.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        foreach (idx[i]) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx[i];
            cfg_ch.data  <= val[i];
            do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
            scoreboard.write_reg(idx[i], val[i]);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin : result_sink
        int      stall;
        bit      burst;
        t_result got;
        stall = 0;
        burst = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                got.trigger_start        = out_ch.trigger_start;
                got.reading_accepted     = out_ch.reading_accepted;
                got.filtered_distance_cm = out_ch.filtered_distance_cm;
                got.has_reading          = out_ch.has_reading;
                scoreboard.check_result(got);
                if ($urandom_range(0, 39) == 0) burst = !burst;
                stall = draw_wait(burst);
            end else if (stall > 0) begin
                stall--;
            end
            out_ch.ready <= (stall == 0);
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        int unsigned lo_cm;
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.echo_ready <= 1'b0;
        in_ch.echo_ticks <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= '0;
        cfg_ch.data      <= '0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed ticks at reset settings: no echo, extremes, window edges, ring fill
        send_tick(1'b0, '0);
        send_tick(1'b0, '1);
        send_tick(1'b1, '0);
        send_tick(1'b1, '1);
        send_tick(1'b1, ticks_for_cm(MIN_CM_RST) - TICKS_W'(1));
        send_tick(1'b1, ticks_for_cm(MIN_CM_RST));
        send_tick(1'b1, ticks_for_cm(MAX_CM_RST + 1) - TICKS_W'(1));
        send_tick(1'b1, ticks_for_cm(MAX_CM_RST + 1));
        send_tick(1'b1, 24'hAAAAAA);
        send_tick(1'b1, 24'h555555);
        send_tick(1'b1, ticks_for_cm(100));
        send_tick(1'b1, ticks_for_cm(250));
        send_tick(1'b1, ticks_for_cm(399));
        send_tick(1'b1, ticks_for_cm(37));
        send_tick(1'b1, ticks_for_cm(180));
        send_tick(1'b1, ticks_for_cm(3));
        send_tick(1'b0, ticks_for_cm(200));

        // widest window, slowest trigger, largest step
        write_settings(10'd255, 10'd1023, 10'd0, 10'd1023);
        send_random_ticks(TICKS_PER_PHASE);
        // period dropped below the elapsed time; only the top distance passes
        write_settings(10'd1, 10'd1, 10'd1023, 10'd1023);
        send_random_ticks(TICKS_PER_PHASE);
        // zero period, inverted window, tick data with bits above the field
        write_settings(10'h3FF, 10'd0, 10'd500, 10'd100);
        send_random_ticks(TICKS_PER_PHASE);
        // zero step: the timer never moves
        write_settings(10'd0, 10'd700, MIN_CM_RST, MAX_CM_RST);
        send_random_ticks(TICKS_PER_PHASE);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            lo_cm = $urandom_range(0, 600);
            write_settings(CFG_DATA_W'($urandom_range(1, 255)),
                           CFG_DATA_W'($urandom_range(1, 1023)),
                           CFG_DATA_W'(lo_cm), CFG_DATA_W'($urandom_range(lo_cm, 1023)));
            send_random_ticks(TICKS_PER_PHASE);
        end

        in_ch.valid <= 1'b0;
        while (scoreboard.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (scoreboard.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
